// ===== sv/bxavg_pkg.sv =====
// Shared types, constants and helpers for the box average decimator.
`timescale 1ns / 1ps

package bxavg_pkg;

    // Geometry
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int CELL_SIZE  = 9;
    localparam int HALF       = CELL_SIZE / 2;
    localparam int TAIL       = CELL_SIZE - 1 - HALF;
    localparam int NUM_CELLS  = MAX_WIDTH / CELL_SIZE;

    // Configuration port
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 3;
    localparam int THR_W       = 8;

    // Clamped sizes must hold the maxima and the raw register width
    localparam int SIZE_W0 = ($clog2(MAX_WIDTH + 1) > CFG_DATA_W) ?
                             $clog2(MAX_WIDTH + 1) : CFG_DATA_W;
    localparam int SIZE_W  = ($clog2(MAX_HEIGHT + 1) > SIZE_W0) ?
                             $clog2(MAX_HEIGHT + 1) : SIZE_W0;

    // Position counters
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int PHASE_W    = $clog2(CELL_SIZE);
    localparam int COL_CELL_W = $clog2((MAX_WIDTH - 1 + HALF) / CELL_SIZE + 1);
    localparam int ROW_CELL_W = $clog2((MAX_HEIGHT - 1 + HALF) / CELL_SIZE + 1);
    localparam int CELL_IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

    // Pixel and brightness
    localparam int PIX_W        = 8;
    localparam int LUMA_SUM_W   = PIX_W + 2;
    localparam int RECIP3       = 683;
    localparam int RECIP3_SHIFT = 11;
    localparam int LUMA_PROD_W  = LUMA_SUM_W + 10;

    // Window sums and the scaled compare against thresholds
    localparam int SUM_W = $clog2(CELL_SIZE * CELL_SIZE * 255 + 1);
    localparam int CMP_W = $clog2(2 * CELL_SIZE * CELL_SIZE * 256 + 1);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam int LEVEL_W    = 3;
    localparam int NUM_THR    = 4;
    localparam int NUM_CODES  = 4;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_LEVEL4       = 3'd2,
        REG_LEVEL3       = 3'd3,
        REG_LEVEL2       = 3'd4,
        REG_LEVEL1       = 3'd5
    } cfg_reg_t;

    // Output levels
    typedef enum logic [LEVEL_W-1:0] {
        LEVEL_BLANK = 3'd0,
        LEVEL_DOT   = 3'd1,
        LEVEL_AMP   = 3'd2,
        LEVEL_HASH  = 3'd3,
        LEVEL_AT    = 3'd4
    } level_t;

    // Register values after reset
    localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = 13'd640;
    localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 13'd480;
    localparam logic [THR_W-1:0]      RESET_LEVEL4 = 8'd200;
    localparam logic [THR_W-1:0]      RESET_LEVEL3 = 8'd150;
    localparam logic [THR_W-1:0]      RESET_LEVEL2 = 8'd100;
    localparam logic [THR_W-1:0]      RESET_LEVEL1 = 8'd50;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } geometry_t;

    typedef struct packed {
        logic [THR_W-1:0] level4;
        logic [THR_W-1:0] level3;
        logic [THR_W-1:0] level2;
        logic [THR_W-1:0] level1;
    } thresholds_t;

    // One classified pixel handed from front to back
    typedef struct packed {
        logic [CELL_IDX_W-1:0] cell_index;
        logic [PIX_W-1:0]      luma;
        logic                  first;
        logic                  last;
        logic                  row_edge;
        logic                  col_edge;
        logic                  row_end;
        logic                  frame_end;
    } work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Twice the pixel count of a window; edge cells are clipped to TAIL+1
    function automatic logic [CMP_W-1:0] two_count(input logic row_edge,
                                                    input logic col_edge);
        int rows;
        int cols;
        rows = row_edge ? (TAIL + 1) : CELL_SIZE;
        cols = col_edge ? (TAIL + 1) : CELL_SIZE;
        return CMP_W'(2 * rows * cols);
    endfunction

endpackage

// ===== sv/bxavg_front.sv =====
// Front end: pixel counters, brightness and window classification.
`timescale 1ns / 1ps

module bxavg_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [7:0]                blue_value,
    input  logic [7:0]                green_value,
    input  logic [7:0]                red_value,
    input  logic                      frame_start,
    input  bxavg_pkg::geometry_t      geometry,
    input  bxavg_pkg::queue_status_t  queue_status,
    output logic                      push,
    output bxavg_pkg::work_t          push_word
);
    import bxavg_pkg::*;

    localparam int CELLX_W = (COL_CELL_W > ROW_CELL_W) ? COL_CELL_W : ROW_CELL_W;
    localparam int XW0     = CELLX_W + $clog2(CELL_SIZE + 1) + 2;
    localparam int XW      = (XW0 > SIZE_W + 1) ? XW0 : SIZE_W + 1;

    localparam logic [PHASE_W-1:0] PHASE_START = PHASE_W'(HALF);
    localparam logic [PHASE_W-1:0] PHASE_LAST  = PHASE_W'(CELL_SIZE - 1);

    logic [COL_W-1:0]      col_reg, col_next;
    logic [PHASE_W-1:0]    col_phase_reg, col_phase_next;
    logic [COL_CELL_W-1:0] col_cell_reg, col_cell_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [PHASE_W-1:0]    row_phase_reg, row_phase_next;
    logic [ROW_CELL_W-1:0] row_cell_reg, row_cell_next;

    logic [COL_W-1:0]      col;
    logic [PHASE_W-1:0]    col_phase;
    logic [COL_CELL_W-1:0] col_cell;
    logic [ROW_W-1:0]      row;
    logic [PHASE_W-1:0]    row_phase;
    logic [ROW_CELL_W-1:0] row_cell;

    logic [XW-1:0] width_x, height_x;
    logic [XW-1:0] col_x, row_x;
    logic [XW-1:0] col_span1, col_span2, row_span1, row_span2;

    logic                   accept;
    logic                   in_image, cells_ok, contributes;
    logic                   first_col, first_row;
    logic [LUMA_SUM_W-1:0]  luma_sum;
    logic [LUMA_PROD_W-1:0] luma_prod;

    assign accept = in_valid && !queue_status.full;

    // Frame start restarts the counters before this word is placed
    always_comb
    begin
        if (frame_start)
        begin
            col       = '0;
            col_phase = PHASE_START;
            col_cell  = '0;
            row       = '0;
            row_phase = PHASE_START;
            row_cell  = '0;
        end
        else
        begin
            col       = col_reg;
            col_phase = col_phase_reg;
            col_cell  = col_cell_reg;
            row       = row_reg;
            row_phase = row_phase_reg;
            row_cell  = row_cell_reg;
        end
    end

    // Widen everything to one compare width
    assign width_x   = XW'(geometry.width);
    assign height_x  = XW'(geometry.height);
    assign col_x     = XW'(col);
    assign row_x     = XW'(row);
    assign col_span1 = XW'((XW'(col_cell) + XW'(1)) * XW'(CELL_SIZE));
    assign col_span2 = XW'((XW'(col_cell) + XW'(2)) * XW'(CELL_SIZE));
    assign row_span1 = XW'((XW'(row_cell) + XW'(1)) * XW'(CELL_SIZE));
    assign row_span2 = XW'((XW'(row_cell) + XW'(2)) * XW'(CELL_SIZE));

    // Classify the pixel against its cell window
    always_comb
    begin
        in_image    = (col_x < width_x) && (row_x < height_x);
        cells_ok    = (col_span1 <= width_x) && (row_span1 <= height_x) &&
                      (XW'(col_cell) < XW'(NUM_CELLS));
        contributes = in_image && cells_ok;
        first_col   = (col_cell == '0) ? (col == '0) : (col_phase == '0);
        first_row   = (row_cell == '0) ? (row == '0) : (row_phase == '0);
    end

    // Brightness: divide the component sum by three through a reciprocal
    assign luma_sum  = LUMA_SUM_W'(blue_value) + LUMA_SUM_W'(green_value) +
                       LUMA_SUM_W'(red_value);
    assign luma_prod = LUMA_PROD_W'(luma_sum) * LUMA_PROD_W'(RECIP3);

    always_comb
    begin
        push_word.cell_index = col_cell[CELL_IDX_W-1:0];
        push_word.luma      = luma_prod[RECIP3_SHIFT +: PIX_W];
        push_word.first     = first_col && first_row;
        push_word.last      = (col_phase == PHASE_LAST) && (row_phase == PHASE_LAST);
        push_word.row_edge  = (row_cell == '0);
        push_word.col_edge  = (col_cell == '0);
        push_word.row_end   = (width_x < col_span2);
        push_word.frame_end = (width_x < col_span2) && (height_x < row_span2);
    end

    assign push = accept && contributes;

    // Advance the raster position
    always_comb
    begin
        col_next       = col + COL_W'(1);
        col_phase_next = col_phase;
        col_cell_next  = col_cell;
        row_next       = row;
        row_phase_next = row_phase;
        row_cell_next  = row_cell;
        if (col_phase == PHASE_LAST)
        begin
            col_phase_next = '0;
            col_cell_next  = col_cell + COL_CELL_W'(1);
        end
        else
        begin
            col_phase_next = col_phase + PHASE_W'(1);
        end
        if (col_x + XW'(1) >= width_x)
        begin
            col_next       = '0;
            col_phase_next = PHASE_START;
            col_cell_next  = '0;
            if (row_x + XW'(1) >= height_x)
            begin
                row_next       = '0;
                row_phase_next = PHASE_START;
                row_cell_next  = '0;
            end
            else
            begin
                row_next = row + ROW_W'(1);
                if (row_phase == PHASE_LAST)
                begin
                    row_phase_next = '0;
                    row_cell_next  = row_cell + ROW_CELL_W'(1);
                end
                else
                begin
                    row_phase_next = row_phase + PHASE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            col_phase_reg <= PHASE_START;
            col_cell_reg  <= '0;
            row_reg       <= '0;
            row_phase_reg <= PHASE_START;
            row_cell_reg  <= '0;
        end
        else if (accept)
        begin
            col_reg       <= col_next;
            col_phase_reg <= col_phase_next;
            col_cell_reg  <= col_cell_next;
            row_reg       <= row_next;
            row_phase_reg <= row_phase_next;
            row_cell_reg  <= row_cell_next;
        end
    end

endmodule

// ===== sv/bxavg_queue.sv =====
// Short register queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module bxavg_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  bxavg_pkg::work_t          push_word,
    input  logic                      pop,
    output bxavg_pkg::work_t          head_word,
    output bxavg_pkg::queue_status_t  queue_status
);
    import bxavg_pkg::*;

    work_t              slot_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign queue_status.full  = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign queue_status.empty = (count_reg == '0);
    assign head_word          = slot_reg[rd_ptr_reg];

    // Move the pointers and the fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          wr_ptr_reg + Q_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          rd_ptr_reg + Q_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!queue_status.full || pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !queue_status.empty)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");
`endif

endmodule

// ===== sv/bxavg_back.sv =====
// Back end: window sum memory update, average compare and level output.
`timescale 1ns / 1ps

module bxavg_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bxavg_pkg::thresholds_t    thresholds,
    input  bxavg_pkg::work_t          head_word,
    input  bxavg_pkg::queue_status_t  queue_status,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                cell_level,
    output logic                      cell_row_end,
    output logic                      cell_frame_end
);
    import bxavg_pkg::*;

    logic [SUM_W-1:0] cell_mem [NUM_CELLS];

    // Sum stage
    logic                  r_valid_reg;
    work_t                 r_word_reg;
    logic [SUM_W-1:0]      rdata_reg;
    logic                  fwd_valid_reg;
    logic [CELL_IDX_W-1:0] fwd_cell_reg;
    logic [SUM_W-1:0]      fwd_data_reg;
    logic [SUM_W-1:0]      operand;
    logic [SUM_W-1:0]      sum;
    logic                  r_adv;

    // Compare stage
    logic             s2_valid_reg;
    logic [CMP_W-1:0] s2_value_reg;
    logic [1:0]       s2_code_reg;
    logic             s2_row_end_reg;
    logic             s2_frame_end_reg;
    logic             s2_ready;
    logic             s2_adv;
    level_t           level;

    // Output register
    logic       out_valid_reg;
    logic [2:0] out_level_reg;
    logic       out_row_end_reg;
    logic       out_frame_end_reg;
    logic       out_ready;

    logic [CMP_W-1:0] bound_reg [NUM_THR][NUM_CODES];
    logic [THR_W-1:0] thr [NUM_THR];

    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s2_adv    = s2_valid_reg && out_ready;
    assign r_adv     = r_valid_reg && (!r_word_reg.last || s2_ready);
    assign pop       = !queue_status.empty && (!r_valid_reg || r_adv);

    // Scaled thresholds: the rounded average exceeds T exactly when 2*sum + n >= 2*n*(T+1)
    assign thr[3] = thresholds.level4;
    assign thr[2] = thresholds.level3;
    assign thr[1] = thresholds.level2;
    assign thr[0] = thresholds.level1;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_THR; k++)
        begin
            for (int c = 0; c < NUM_CODES; c++)
            begin
                bound_reg[k][c] <= CMP_W'((CMP_W'(thr[k]) + CMP_W'(1)) *
                                   two_count(c[1], c[0]));
            end
        end
    end

    // Take the newest write when the memory read is one write behind
    always_comb
    begin
        if (fwd_valid_reg && (fwd_cell_reg == r_word_reg.cell_index))
        begin
            operand = fwd_data_reg;
        end
        else
        begin
            operand = rdata_reg;
        end
        if (r_word_reg.first)
        begin
            sum = SUM_W'(r_word_reg.luma);
        end
        else
        begin
            sum = operand + SUM_W'(r_word_reg.luma);
        end
    end

    // Read the window sum on pop
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rdata_reg  <= cell_mem[head_word.cell_index];
            r_word_reg <= head_word;
        end
    end

    // Write back the updated sum
    always_ff @(posedge clk)
    begin
        if (r_adv)
        begin
            cell_mem[r_word_reg.cell_index] <= sum;
            fwd_cell_reg                    <= r_word_reg.cell_index;
            fwd_data_reg                    <= sum;
        end
    end

    // Pass a finished window on to the compare stage
    always_ff @(posedge clk)
    begin
        if (r_adv && r_word_reg.last)
        begin
            s2_value_reg     <= CMP_W'({sum, 1'b0}) +
                                (two_count(r_word_reg.row_edge, r_word_reg.col_edge) >> 1);
            s2_code_reg      <= {r_word_reg.row_edge, r_word_reg.col_edge};
            s2_row_end_reg   <= r_word_reg.row_end;
            s2_frame_end_reg <= r_word_reg.frame_end;
        end
    end

    // Quantize from the top level down
    always_comb
    begin
        if (s2_value_reg >= bound_reg[3][s2_code_reg])
        begin
            level = LEVEL_AT;
        end
        else if (s2_value_reg >= bound_reg[2][s2_code_reg])
        begin
            level = LEVEL_HASH;
        end
        else if (s2_value_reg >= bound_reg[1][s2_code_reg])
        begin
            level = LEVEL_AMP;
        end
        else if (s2_value_reg >= bound_reg[0][s2_code_reg])
        begin
            level = LEVEL_DOT;
        end
        else
        begin
            level = LEVEL_BLANK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            out_level_reg     <= level;
            out_row_end_reg   <= s2_row_end_reg;
            out_frame_end_reg <= s2_frame_end_reg;
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                r_valid_reg <= 1'b1;
            end
            else if (r_adv)
            begin
                r_valid_reg <= 1'b0;
            end
            if (r_adv)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (r_adv && r_word_reg.last)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign cell_level     = out_level_reg;
    assign cell_row_end   = out_row_end_reg;
    assign cell_frame_end = out_frame_end_reg;

`ifndef ASSERT_OFF
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        r_adv |-> (CELL_IDX_W'(r_word_reg.cell_index) < CELL_IDX_W'(NUM_CELLS)))
        else $error("window sum write beyond the cell memory");
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_level_reg <= LEVEL_AT))
        else $error("output level out of range");
    a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_frame_end_reg) |-> out_row_end_reg)
        else $error("frame end without row end");
    a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid_reg && r_word_reg.last && !s2_ready) |=> r_valid_reg)
        else $error("finished window dropped while compare stage busy");
`endif

endmodule

// ===== sv/box_average_decimate_to_levels.sv =====
// Top level: configuration registers and the front, queue and back parts.
//
//   channel   direction  handshake              payload
//   pixel     in         in_valid / in_stall    blue_value green_value red_value frame_start
//   cell      out        out_valid / out_stall  cell_level cell_row_end cell_frame_end
//   config    in         cfg_write_enable       cfg_index cfg_data
//
// One pixel word is taken per clock unless stalled; a cell word passes the
// queue, sum, compare and output registers after its closing pixel. The back
// end does one read-modify-write of the sum memory per clock unless stalled,
// forwarding each write to the next read. Reset presets the config registers,
// clears counters and valid bits; the sum memory needs no clearing. A stalled
// output backs up into the compare stage and four-entry queue before in_stall rises.
`timescale 1ns / 1ps

module box_average_decimate_to_levels (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        blue_value,
    input  logic [7:0]                        green_value,
    input  logic [7:0]                        red_value,
    input  logic                              frame_start,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        cell_level,
    output logic                              cell_row_end,
    output logic                              cell_frame_end,
    input  logic                              cfg_write_enable,
    input  logic [bxavg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bxavg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bxavg_pkg::*;

    logic [CFG_DATA_W-1:0] image_width_reg;
    logic [CFG_DATA_W-1:0] image_height_reg;
    logic [THR_W-1:0]      level4_reg;
    logic [THR_W-1:0]      level3_reg;
    logic [THR_W-1:0]      level2_reg;
    logic [THR_W-1:0]      level1_reg;

    geometry_t     geometry;
    thresholds_t   thresholds;
    queue_status_t queue_status;
    work_t         push_word;
    work_t         head_word;
    logic          push;
    logic          pop;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= RESET_WIDTH;
            image_height_reg <= RESET_HEIGHT;
            level4_reg       <= RESET_LEVEL4;
            level3_reg       <= RESET_LEVEL3;
            level2_reg       <= RESET_LEVEL2;
            level1_reg       <= RESET_LEVEL1;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                REG_LEVEL4:       level4_reg       <= cfg_data[THR_W-1:0];
                REG_LEVEL3:       level3_reg       <= cfg_data[THR_W-1:0];
                REG_LEVEL2:       level2_reg       <= cfg_data[THR_W-1:0];
                REG_LEVEL1:       level1_reg       <= cfg_data[THR_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp sizes to the supported range
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            geometry.width = SIZE_W'(1);
        end
        else if (SIZE_W'(image_width_reg) > SIZE_W'(MAX_WIDTH))
        begin
            geometry.width = SIZE_W'(MAX_WIDTH);
        end
        else
        begin
            geometry.width = SIZE_W'(image_width_reg);
        end
        if (image_height_reg == '0)
        begin
            geometry.height = SIZE_W'(1);
        end
        else if (SIZE_W'(image_height_reg) > SIZE_W'(MAX_HEIGHT))
        begin
            geometry.height = SIZE_W'(MAX_HEIGHT);
        end
        else
        begin
            geometry.height = SIZE_W'(image_height_reg);
        end
    end

    assign thresholds.level4 = level4_reg;
    assign thresholds.level3 = level3_reg;
    assign thresholds.level2 = level2_reg;
    assign thresholds.level1 = level1_reg;

    assign in_stall = queue_status.full;

    bxavg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .blue_value   (blue_value),
        .green_value  (green_value),
        .red_value    (red_value),
        .frame_start  (frame_start),
        .geometry     (geometry),
        .queue_status (queue_status),
        .push         (push),
        .push_word    (push_word)
    );

    bxavg_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_word    (push_word),
        .pop          (pop),
        .head_word    (head_word),
        .queue_status (queue_status)
    );

    bxavg_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .thresholds     (thresholds),
        .head_word      (head_word),
        .queue_status   (queue_status),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cell_level     (cell_level),
        .cell_row_end   (cell_row_end),
        .cell_frame_end (cell_frame_end)
    );

endmodule
